[hdl/ackermann_steering_angles_macros.svh]
// Assertion macros shared by the steering-angle modules
`ifndef ACKERMANN_STEERING_ANGLES_MACROS_SVH
`define ACKERMANN_STEERING_ANGLES_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define ASA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/asa_pkg.sv]
// Shared constants, types and tables of the Ackermann steering block
`timescale 1ns / 1ps
package asa_pkg;

	localparam int ANGLE_FRAC_BITS = 16;
	localparam int RW     = ANGLE_FRAC_BITS + 3;   // rotation CORDIC word
	localparam int VW     = ANGLE_FRAC_BITS + 16;  // vectoring CORDIC word
	localparam int MAG_W  = 14;
	localparam int ANG_W  = 15;
	localparam int LEN_W  = 12;
	localparam int CFG_W  = 14;
	localparam int QSH    = 32 - ANGLE_FRAC_BITS;

	localparam logic [63:0] QHALF          = (64'd1 << QSH) >> 1;
	localparam logic [63:0] PI_Q32         = 64'd13493037705;
	localparam logic [63:0] KINV_Q32       = 64'd2608131496;
	localparam logic [63:0] CDEG_HALF_TURN = 64'd18000;
	localparam logic [63:0] PI_DIV         = PI_Q32 / CDEG_HALF_TURN;
	localparam logic [63:0] PI_REM         = PI_Q32 % CDEG_HALF_TURN;
	localparam logic [63:0] RND_BIAS       = CDEG_HALF_TURN / 2;
	// 18000 = 16 * 1125: shift by four, then reciprocal of 1125
	localparam int          DIV_SH         = 31;
	localparam logic [63:0] DIV_K          = 64'd1125;
	localparam logic [63:0] DIV_RECIP      = (64'd1 << DIV_SH) / DIV_K;
	// radians back to cdeg
	localparam int          ZSH            = ANGLE_FRAC_BITS + 15;
	localparam logic [63:0] ZMUL           = CDEG_HALF_TURN << QSH;
	localparam logic [63:0] ZRECIP         = (CDEG_HALF_TURN << (QSH + ZSH)) / PI_Q32;
	localparam logic [63:0] PI_HALF        = PI_Q32 / 2;

	localparam int RIGHT_ANGLE = 9000;
	localparam int MIN_RAD2    = 200;   // twice the minimum turn radius, mm

	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		REG_WHEELBASE = 2'd0,
		REG_TRACK     = 2'd1,
		REG_MAX_INNER = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic             kill;
	} asa_tag_t;

	typedef struct packed {
		asa_tag_t              tag;
		logic signed [RW-1:0]  theta;
	} asa_item_t;

	function automatic logic [63:0] q32_to_qf(input logic [63:0] v);
		return (v + QHALF) >> QSH;
	endfunction

	function automatic logic signed [RW-1:0] atan_qf(input int i);
		logic [63:0] a;
		case (i)
			0:  a = 64'd3373259426;
			1:  a = 64'd1991351318;
			2:  a = 64'd1052175346;
			3:  a = 64'd534100635;
			4:  a = 64'd268086748;
			5:  a = 64'd134174063;
			6:  a = 64'd67103403;
			7:  a = 64'd33553749;
			8:  a = 64'd16777131;
			9:  a = 64'd8388597;
			10: a = 64'd4194303;
			11: a = 64'd2097152;
			12: a = 64'd1048576;
			13: a = 64'd524288;
			14: a = 64'd262144;
			15: a = 64'd131072;
			16: a = 64'd65536;
			17: a = 64'd32768;
			18: a = 64'd16384;
			19: a = 64'd8192;
			20: a = 64'd4096;
			21: a = 64'd2048;
			22: a = 64'd1024;
			23: a = 64'd512;
			24: a = 64'd256;
			25: a = 64'd128;
			26: a = 64'd64;
			27: a = 64'd32;
			28: a = 64'd16;
			29: a = 64'd8;
			30: a = 64'd4;
			default: a = 64'd2;
		endcase
		return RW'(q32_to_qf(a));
	endfunction

endpackage

[hdl/asa_front.sv]
// Front end: accepts commands, clamps, flags trivial cases, converts cdeg to radians
`timescale 1ns / 1ps
module asa_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [asa_pkg::ANG_W-1:0] wheel_angle_cdeg,
	input  logic [asa_pkg::MAG_W-1:0]      max_inner_cdeg,
	input  logic                           full,
	output logic                           push,
	output asa_pkg::asa_item_t             push_item
);
	import asa_pkg::*;

	localparam int HI_W = 34;
	localparam int V_W  = 25;
	localparam int V4_W = V_W - 4;
	localparam int QE_W = 11;
	localparam int PR_W = V4_W + 21;
	localparam int TQ_W = HI_W + 1;

	logic                en;
	logic [5:1]          vld_q;
	logic [ANG_W-1:0]    magu;
	logic [MAG_W-1:0]    mag_c;
	asa_tag_t            tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [HI_W-1:0]     hi_s2, hi_s3, hi_s4;
	logic [V_W-1:0]      v_s2;
	logic [V4_W-1:0]     v4_s3;
	logic [QE_W-1:0]     qe_s3, q_s4;
	logic [PR_W-1:0]     prod;
	logic [V4_W:0]       rem;
	logic [TQ_W-1:0]     thq;
	logic signed [RW-1:0] theta_s5;

	assign en       = !(vld_q[5] && full);
	assign in_ready = en;
	assign push     = vld_q[5] && !full;
	assign push_item = '{tag: tag_s5, theta: theta_s5};

	always_comb begin
		magu  = wheel_angle_cdeg[ANG_W-1] ? ANG_W'(-wheel_angle_cdeg) : wheel_angle_cdeg;
		mag_c = (magu > {1'b0, max_inner_cdeg}) ? max_inner_cdeg : magu[MAG_W-1:0];
		prod  = PR_W'(v_s2[V_W-1:4]) * PR_W'(DIV_RECIP);
		rem   = (V4_W+1)'(v4_s3) - (V4_W+1)'(qe_s3) * (V4_W+1)'(DIV_K);
		thq   = TQ_W'(hi_s4) + TQ_W'(q_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1.neg  <= wheel_angle_cdeg[ANG_W-1];
			tag_s1.mag  <= mag_c;
			tag_s1.kill <= (mag_c == '0) || (mag_c >= MAG_W'(RIGHT_ANGLE));
			// angle*pi/18000 split into whole and remainder parts
			tag_s2 <= tag_s1;
			hi_s2  <= HI_W'(tag_s1.mag) * HI_W'(PI_DIV);
			v_s2   <= V_W'(tag_s1.mag) * V_W'(PI_REM) + V_W'(RND_BIAS);
			tag_s3 <= tag_s2;
			hi_s3  <= hi_s2;
			v4_s3  <= v_s2[V_W-1:4];
			qe_s3  <= prod[DIV_SH +: QE_W];
			// reciprocal estimate is low by at most one
			tag_s4 <= tag_s3;
			hi_s4  <= hi_s3;
			q_s4   <= qe_s3 + QE_W'(rem >= (V4_W+1)'(DIV_K));
			tag_s5   <= tag_s4;
			theta_s5 <= RW'((64'(thq) + QHALF) >> QSH);
		end
	end

	`include "ackermann_steering_angles_macros.svh"

	`ASA_ASSERT_NXT(a_front_hold, vld_q[5] && full, vld_q[5] && $stable(theta_s5), "front stall lost its item")

endmodule

[hdl/asa_queue.sv]
// Short queue between the front end and the CORDIC back end
`timescale 1ns / 1ps
module asa_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  asa_pkg::asa_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output asa_pkg::asa_item_t pop_item
);
	import asa_pkg::*;

	asa_item_t        mem_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]   cnt_q;

	assign full     = (cnt_q == QCW'(QDEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	`include "ackermann_steering_angles_macros.svh"

	`ASA_ASSERT_IMP(a_q_bound, 1'b1, cnt_q <= QCW'(QDEPTH), "queue overfilled")
	`ASA_ASSERT_IMP(a_q_pop, pop, cnt_q != '0, "pop from empty queue")

endmodule

[hdl/asa_back.sv]
// Back end: rotation CORDIC, geometry products, vectoring CORDIC, cdeg conversion
`timescale 1ns / 1ps
module asa_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	output logic                            pop,
	input  asa_pkg::asa_item_t              pop_item,
	input  logic [asa_pkg::LEN_W-1:0]       wheelbase_mm,
	input  logic [asa_pkg::LEN_W-1:0]       track_mm,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [asa_pkg::ANG_W-1:0] inner_angle_cdeg,
	output logic signed [asa_pkg::ANG_W-1:0] outer_angle_cdeg
);
	import asa_pkg::*;

	localparam int F     = ANGLE_FRAC_BITS;
	localparam int NSTG  = 2 * F + 7;
	localparam int P_IDX = F + 1;
	localparam int V0    = F + 2;
	localparam int NZW   = 52;
	localparam int PRW   = RW + 28;
	localparam int QW    = 16;

	logic                 en;
	logic [NSTG-1:0]      vld_q;
	asa_tag_t             tag_q [0:NSTG-2];
	logic signed [RW-1:0] rx_s [0:F];
	logic signed [RW-1:0] ry_s [0:F];
	logic signed [RW-1:0] rz_s [0:F];
	logic signed [VW-1:0] vx_s [0:F];
	logic signed [VW-1:0] vy_s [0:F];
	logic signed [RW-1:0] vz_s [0:F];
	logic signed [VW-1:0] p_lc_s, p_ts_s, p_ls_s, p_rs_s;
	logic signed [LEN_W:0] l_sx, t_sx, t_adj;
	logic signed [VW+1:0] radius_chk;
	logic [RW-2:0]        zc;
	logic [NZW-1:0]       nz_c1, nz_c2, nz_c3, qp_c3;
	logic [PRW-1:0]       pr_c1;
	logic [QW-1:0]        qe_c2, qe_c3, cd, cd_lim;
	logic signed [NZW:0]  rem;
	logic                 out_kill_q;

	assign en        = !vld_q[NSTG-1] || out_ready;
	assign pop       = q_valid && en;
	assign out_valid = vld_q[NSTG-1];

	always_comb begin
		l_sx  = signed'({1'b0, wheelbase_mm});
		t_sx  = signed'({1'b0, track_mm});
		t_adj = t_sx - (LEN_W+1)'(MIN_RAD2);
		// R < 100 mm  <=>  2*L*cos + (T-200)*sin < 0
		radius_chk = ((VW+2)'(p_lc_s) <<< 1) + (VW+2)'(p_rs_s);
		zc  = vz_s[F][RW-1] ? '0 : vz_s[F][RW-2:0];
		rem = signed'((NZW+1)'(nz_c3)) - signed'((NZW+1)'(qp_c3));
		if (rem < 0)
			cd = qe_c3 - 1'b1;
		else if (rem >= signed'((NZW+1)'(PI_Q32)))
			cd = qe_c3 + 1'b1;
		else
			cd = qe_c3;
		cd_lim = (cd > QW'(RIGHT_ANGLE)) ? QW'(RIGHT_ANGLE) : cd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], pop};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0] <= pop_item.tag;
			for (int k = 1; k < NSTG - 1; k++) begin
				if (k == P_IDX)
					tag_q[k] <= '{neg: tag_q[k-1].neg, mag: tag_q[k-1].mag,
						kill: tag_q[k-1].kill | (ry_s[F] <= 0)};
				else if (k == V0)
					tag_q[k] <= '{neg: tag_q[k-1].neg, mag: tag_q[k-1].mag,
						kill: tag_q[k-1].kill | (radius_chk < 0)};
				else
					tag_q[k] <= tag_q[k-1];
			end

			// rotation: cos and sin of the inner angle
			rx_s[0] <= RW'(q32_to_qf(KINV_Q32));
			ry_s[0] <= '0;
			rz_s[0] <= pop_item.theta;
			for (int i = 0; i < F; i++) begin
				if (rz_s[i] >= 0) begin
					rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
					rz_s[i+1] <= rz_s[i] - atan_qf(i);
				end else begin
					rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
					rz_s[i+1] <= rz_s[i] + atan_qf(i);
				end
			end

			p_lc_s <= VW'(l_sx) * VW'(rx_s[F]);
			p_ts_s <= VW'(t_sx) * VW'(ry_s[F]);
			p_ls_s <= VW'(l_sx) * VW'(ry_s[F]);
			p_rs_s <= VW'(t_adj) * VW'(ry_s[F]);

			// vectoring: atan2(L*sin, L*cos + T*sin)
			vx_s[0] <= p_lc_s + p_ts_s;
			vy_s[0] <= p_ls_s;
			vz_s[0] <= '0;
			for (int i = 0; i < F; i++) begin
				if (vy_s[i] > 0) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + atan_qf(i);
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - atan_qf(i);
				end
			end

			// radians to cdeg: reciprocal estimate, then exact remainder fix-up
			nz_c1 <= NZW'(zc) * NZW'(ZMUL) + NZW'(PI_HALF);
			pr_c1 <= PRW'(zc) * PRW'(ZRECIP);
			nz_c2 <= nz_c1;
			qe_c2 <= QW'((pr_c1 + (PRW'(1) << (ZSH - 1))) >> ZSH);
			nz_c3 <= nz_c2;
			qe_c3 <= qe_c2;
			qp_c3 <= NZW'(qe_c2) * NZW'(PI_Q32);

			out_kill_q <= tag_q[NSTG-2].kill;
			if (tag_q[NSTG-2].kill) begin
				inner_angle_cdeg <= '0;
				outer_angle_cdeg <= '0;
			end else if (tag_q[NSTG-2].neg) begin
				inner_angle_cdeg <= -signed'(ANG_W'(tag_q[NSTG-2].mag));
				outer_angle_cdeg <= -signed'(ANG_W'(cd_lim));
			end else begin
				inner_angle_cdeg <= signed'(ANG_W'(tag_q[NSTG-2].mag));
				outer_angle_cdeg <= signed'(ANG_W'(cd_lim));
			end
		end
	end

	`include "ackermann_steering_angles_macros.svh"

	`ASA_ASSERT_IMP(a_kill_zero, out_valid && out_kill_q, inner_angle_cdeg == '0 && outer_angle_cdeg == '0, "dropped case gave non-zero angles")
	`ASA_ASSERT_IMP(a_outer_rng, out_valid, outer_angle_cdeg <= 15'sd9000 && outer_angle_cdeg >= -15'sd9000, "outer angle beyond right angle")

endmodule

[hdl/ackermann_steering_angles.sv]
// Top level of the Ackermann steering angle block
`timescale 1ns / 1ps
// Ackermann steering angles. Each input beat carries a signed commanded wheel
// angle in centidegrees; its magnitude is clamped to max_inner_cdeg and one
// output beat returns the signed inner angle and the Ackermann outer angle
// atan(L / (L/tan(inner) + T)), both in centidegrees with the input's sign.
// A zero clamped angle, a right angle or more, a vanishing sine, or a turn
// radius under 100 mm gives zero for both. The block takes one beat per clock
// when the output side keeps up: a five-stage front end (clamp, then angle to
// radians through a reciprocal multiply) feeds a four-entry queue, and the back
// end is fully pipelined: 16 rotation CORDIC stages, two product stages, 16
// vectoring CORDIC stages and four conversion stages. An output stall freezes
// the back end and fills the queue, which then holds up the front end; the
// output register holds its beat while ready is low. Registers (wheelbase,
// track, max inner angle) are written through cfg_we/cfg_index/cfg_data and
// should change only while idle.
module ackermann_steering_angles (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [asa_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [asa_pkg::ANG_W-1:0] wheel_angle_cdeg,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [asa_pkg::ANG_W-1:0] inner_angle_cdeg,
	output logic signed [asa_pkg::ANG_W-1:0] outer_angle_cdeg
);
	import asa_pkg::*;

	logic [LEN_W-1:0] wheelbase_q, track_q;
	logic [MAG_W-1:0] max_inner_q;
	logic             push, full, pop, q_valid;
	asa_item_t        push_item, pop_item;

	// config registers; an unused index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= LEN_W'(950);
			track_q     <= LEN_W'(700);
			max_inner_q <= MAG_W'(5400);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WHEELBASE: wheelbase_q <= cfg_data[LEN_W-1:0];
				REG_TRACK:     track_q     <= cfg_data[LEN_W-1:0];
				REG_MAX_INNER: max_inner_q <= cfg_data[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	asa_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.wheel_angle_cdeg (wheel_angle_cdeg),
		.max_inner_cdeg   (max_inner_q),
		.full             (full),
		.push             (push),
		.push_item        (push_item)
	);

	asa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	asa_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.pop              (pop),
		.pop_item         (pop_item),
		.wheelbase_mm     (wheelbase_q),
		.track_mm         (track_q),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.inner_angle_cdeg (inner_angle_cdeg),
		.outer_angle_cdeg (outer_angle_cdeg)
	);

endmodule

[dv/ackermann_steering_angles_tb.sv]
// Testbench for the Ackermann steering angle block: directed and random beats
`timescale 1ns / 1ps
module ackermann_steering_angles_tb;
	import asa_pkg::*;

	localparam int FB = ANGLE_FRAC_BITS;
	localparam logic [63:0] PI_Q = 64'd13493037705;
	localparam logic [63:0] KINV_Q = 64'd2608131496;
	localparam int LAT = 2 * ANGLE_FRAC_BITS + 13;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [ANG_W-1:0] wheel_angle_cdeg;
	logic out_valid;
	logic out_ready;
	logic signed [ANG_W-1:0] inner_angle_cdeg;
	logic signed [ANG_W-1:0] outer_angle_cdeg;

	typedef struct packed {
		logic [ANG_W-1:0] inner;
		logic [ANG_W-1:0] outer;
	} angle_pair_t;

	// steering geometry as currently configured
	logic [LEN_W-1:0] wb_mm, tr_mm;
	logic [MAG_W-1:0] max_cdeg;
	angle_pair_t pending_angles[$];
	int errors;
	int hold_off;      // long receiver hold-off, cycles
	bit rx_gaps;       // random receiver stalls enabled

	ackermann_steering_angles dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("ackermann_steering_angles_tb: done, errors");
		$finish;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_q(logic [63:0] v);
		return longint'((v + ((64'd1 << (32 - FB)) >> 1)) >> (32 - FB));
	endfunction

	function automatic longint atan_step(int i);
		logic [63:0] t[32] = '{
			64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
			64'd268086748, 64'd134174063, 64'd67103403, 64'd33553749,
			64'd16777131, 64'd8388597, 64'd4194303, 64'd2097152,
			64'd1048576, 64'd524288, 64'd262144, 64'd131072,
			64'd65536, 64'd32768, 64'd16384, 64'd8192, 64'd4096, 64'd2048,
			64'd1024, 64'd512, 64'd256, 64'd128, 64'd64, 64'd32, 64'd16,
			64'd8, 64'd4, 64'd2};
		return round_q(t[i]);
	endfunction

	// inner/outer wheel angles for one commanded angle
	function automatic angle_pair_t steer_angles(logic [ANG_W-1:0] cmd);
		angle_pair_t r;
		logic neg;
		longint mag, x, y, z, dx, dy, a, cs, sn, L, T;
		logic [63:0] zq, cdeg;
		neg = cmd[ANG_W-1];
		mag = neg ? (32768 - longint'(cmd)) : longint'(cmd);
		if (mag > max_cdeg) mag = max_cdeg;
		r = '0;
		if (mag == 0 || mag >= RIGHT_ANGLE) return r;
		z = round_q((64'(mag) * PI_Q + 64'd9000) / 64'd18000);
		x = round_q(KINV_Q);
		y = 0;
		for (int i = 0; i < FB; i++) begin
			dx = shr_floor(y, i); dy = shr_floor(x, i); a = atan_step(i);
			if (z >= 0) begin x -= dx; y += dy; z -= a; end
			else begin x += dx; y -= dy; z += a; end
		end
		cs = x; sn = y;
		if (sn <= 0) return r;
		L = wb_mm; T = tr_mm;
		if (2 * L * cs + (T - 200) * sn < 0) return r;
		x = L * cs + T * sn;
		y = L * sn;
		z = 0;
		for (int i = 0; i < FB; i++) begin
			dx = shr_floor(y, i); dy = shr_floor(x, i); a = atan_step(i);
			if (y > 0) begin x += dx; y -= dy; z += a; end
			else begin x -= dx; y += dy; z -= a; end
		end
		if (z < 0) z = 0;
		zq = 64'(z) << (32 - FB);
		cdeg = (zq * 64'd18000 + PI_Q / 2) / PI_Q;
		if (cdeg > 9000) cdeg = 9000;
		r.inner = neg ? ANG_W'(-mag) : ANG_W'(mag);
		r.outer = neg ? ANG_W'(-longint'(cdeg)) : ANG_W'(cdeg);
		return r;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	// result checker: oldest expectation against each output beat
	always @(posedge clk) begin
		angle_pair_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected beat inner %0d outer %0d", $time,
					inner_angle_cdeg, outer_angle_cdeg);
				errors++;
			end else begin
				e = pending_angles.pop_front();
				if (inner_angle_cdeg !== e.inner) begin
					$display("%0t: inner expected %0d got %0d", $time,
						$signed(e.inner), inner_angle_cdeg);
					errors++;
				end
				if (outer_angle_cdeg !== e.outer) begin
					$display("%0t: outer expected %0d got %0d", $time,
						$signed(e.outer), outer_angle_cdeg);
					errors++;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (rx_gaps) out_ready <= ($urandom_range(0, 3) != 0);
		else out_ready <= 1'b1;
	end

	// valid stays high from one beat to the next unless a gap follows
	task automatic send_angle(logic [ANG_W-1:0] cmd, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		wheel_angle_cdeg <= cmd;
		pending_angles.push_back(steer_angles(cmd));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (pending_angles.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (LAT + 10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_WHEELBASE: wb_mm = val[LEN_W-1:0];
			REG_TRACK: tr_mm = val[LEN_W-1:0];
			default: max_cdeg = val[MAG_W-1:0];
		endcase
	endtask

	task automatic set_geometry(int wb, int tr, int mx);
		write_reg(REG_WHEELBASE, CFG_W'(wb));
		write_reg(REG_TRACK, CFG_W'(tr));
		write_reg(REG_MAX_INNER, CFG_W'(mx));
		cfg_we <= 1'b0;
	endtask

	// extremes, sign, clamp, zero, right angle, small radius, zero wheelbase
	task automatic test_directed();
		logic [ANG_W-1:0] pts[12] = '{15'sd0, 15'sd1, -15'sd1, 15'sd9000, -15'sd9000,
			15'sd5400, 15'sd5401, -15'sd5399, 15'sd16383, -15'sd16384, 15'sd4500,
			15'sd100};
		foreach (pts[i]) send_angle(pts[i], 1'b0);
		drain();
		set_geometry(0, 0, 16383);       // zero wheelbase, beyond right angle
		foreach (pts[i]) if (i < 8) send_angle(pts[i], 1'b0);
		drain();
		set_geometry(50, 0, 8999);       // tight radius
		send_angle(15'sd8999, 1'b0);
		send_angle(15'sd3000, 1'b0);
		send_angle(-15'sd200, 1'b0);
		drain();
		set_geometry(4095, 4095, 0);     // clamp everything to zero
		send_angle(15'sd3000, 1'b0);
		send_angle(-15'sd3000, 1'b0);
		drain();
	endtask

	task automatic test_random(int n, bit gaps);
		logic [ANG_W-1:0] v;
		for (int i = 0; i < n; i++) begin
			v = ($urandom_range(0, 7) == 0) ? ANG_W'($urandom)
				: ANG_W'($signed($urandom_range(0, 18000)) - 9000);
			send_angle(v, gaps);
		end
	endtask

	task automatic test_config_sweep();
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_geometry(1, 4000, 8999);
				1: set_geometry(4000, 0, 1);
				2: set_geometry(4095, 4095, 16383);
				default: set_geometry($urandom_range(1, 4000), $urandom_range(0, 4000),
					$urandom_range(0, 8999));
			endcase
			rx_gaps = (p != 1);
			test_random(175, p != 2);
			drain();
		end
	endtask

	// receiver stalls long while the sender keeps offering, then sender pauses
	task automatic test_backpressure();
		set_geometry(950, 700, 5400);
		hold_off = 200;
		test_random(80, 1'b0);
		drain();
		test_random(60, 1'b1);
		drain();
	endtask

	initial begin
		errors = 0;
		hold_off = 0;
		rx_gaps = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WHEELBASE;
		cfg_data = '0;
		in_valid = 1'b0;
		wheel_angle_cdeg = '0;
		wb_mm = 950;
		tr_mm = 700;
		max_cdeg = 5400;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_backpressure();
		if (pending_angles.size() != 0) begin
			$display("%0t: %0d results missing", $time, pending_angles.size());
			errors++;
		end
		if (errors == 0) $display("ackermann_steering_angles_tb: done, clean");
		else $display("ackermann_steering_angles_tb: done, errors");
		$finish;
	end
endmodule

[sim.f]
+incdir+hdl
hdl/asa_pkg.sv
hdl/asa_front.sv
hdl/asa_queue.sv
hdl/asa_back.sv
hdl/ackermann_steering_angles.sv
dv/ackermann_steering_angles_tb.sv
